FILE: src/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the path affine transform
// Command codes, result kinds, register indexes and operand counts.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [2:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_CURVE = 3'd2,
    CMD_CLOSE = 3'd3,
    CMD_RECT  = 3'd4,
    CMD_OVAL  = 3'd5,
    CMD_ARC   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_PASSED  = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_COEF_YX  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_index_t;

  // Number of operand elements that follow a command element.
  function automatic logic [1:0] operand_count(input cmd_t cmd);
    logic [1:0] n;
    case (cmd)
      CMD_MOVE:  n = 2'd1;
      CMD_LINE:  n = 2'd1;
      CMD_CURVE: n = 2'd3;
      CMD_CLOSE: n = 2'd0;
      CMD_RECT:  n = 2'd3;
      CMD_OVAL:  n = 2'd2;
      CMD_ARC:   n = 2'd3;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: src/path_affine_transform.sv
// ----------------------------------------------------------------------------
// path_affine_transform: affine mapping of a streamed vector path
// Parses command and operand elements and maps coordinate operands through
// a 2x3 fixed-point matrix with floor rounding and saturation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (low bits first)   tuser (low bits first)      tlast
//  in_      slave      elem_x, elem_y           -                           elem_last
//  out_     master     res_x, res_y             res_kind, res_bad_command,  res_last
//                                               res_saturated
//  cfg_     slave      cfg_index, cfg_data      -                           -
//
//  One element per cycle sustained while out_tready stays high; the four
//  products are registered in stage A as an element is taken, then the sums,
//  floor shift and saturation fill the output register in stage B.
//  Reset (rst_n low, synchronous) restores the identity matrix and an idle
//  parser. Each of the two stages moves on when the next one is free, so one
//  more element is still taken while a finished result waits on out_tready.
//
module path_affine_transform
  import pat_pkg::*;
#(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int DATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [DATA_W-1:0]          in_tdata,   // elem_x, elem_y, zero pad
  input  logic                       in_tlast,   // elem_last
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [DATA_W-1:0]          out_tdata,  // res_x, res_y, zero pad
  output logic [7:0]                 out_tuser,  // res_kind[1:0], res_bad_command,
                                                 // res_saturated, zero pad
  output logic                       out_tlast,  // res_last
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]     cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = 2 * COORD_WIDTH;
  localparam int SW   = 2 * COORD_WIDTH + 2;
  localparam logic [CW-1:0] ONE       = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] FRAC_MASK = ~({CW{1'b1}} << FRAC_BITS);
  localparam logic [CW-1:0] MAX_CODE  = CW'(CMD_ARC);

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] coef_xx_r, coef_xy_r, coef_yx_r, coef_yy_r;
  logic signed [CW-1:0] offset_x_r, offset_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r  <= ONE;
      coef_xy_r  <= '0;
      coef_yx_r  <= '0;
      coef_yy_r  <= ONE;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_XX:  coef_xx_r  <= cfg_data;
        REG_COEF_XY:  coef_xy_r  <= cfg_data;
        REG_COEF_YX:  coef_yx_r  <= cfg_data;
        REG_COEF_YY:  coef_yy_r  <= cfg_data;
        REG_OFFSET_X: offset_x_r <= cfg_data;
        REG_OFFSET_Y: offset_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic a_valid_r;
  logic a_ready, b_ready;
  logic in_req;

  assign b_ready   = !out_tvalid || out_tready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;
  assign in_req    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- parser
  logic signed [CW-1:0] in_x, in_y;
  logic [CW-1:0]        code_wide;
  logic                 code_ok;
  cmd_t                 cmd_r, cmd_nxt;
  logic [1:0]           ops_left_r, ops_left_nxt;
  logic [1:0]           pos_r, pos_nxt;
  kind_t                kind_nxt;
  logic                 bad_nxt;

  assign in_x      = in_tdata[CW-1:0];
  assign in_y      = in_tdata[PW-1:CW];
  assign code_wide = in_x >> FRAC_BITS;
  assign code_ok   = !in_x[CW-1] && ((in_x & FRAC_MASK) == '0) && (code_wide <= MAX_CODE);

  always_comb begin
    cmd_nxt      = cmd_r;
    ops_left_nxt = ops_left_r;
    pos_nxt      = pos_r;
    kind_nxt     = KIND_COMMAND;
    bad_nxt      = 1'b0;
    if (ops_left_r == 2'd0) begin
      if (code_ok) begin
        cmd_nxt      = cmd_t'(code_wide[2:0]);
        ops_left_nxt = operand_count(cmd_t'(code_wide[2:0]));
        pos_nxt      = 2'd0;
      end else begin
        bad_nxt = 1'b1;
      end
    end else begin
      // The roundness of a rect and the angles of an arc are not coordinates.
      if (pos_r == 2'd2 && (cmd_r == CMD_RECT || cmd_r == CMD_ARC)) begin
        kind_nxt = KIND_PASSED;
      end else begin
        kind_nxt = KIND_POINT;
      end
      ops_left_nxt = ops_left_r - 2'd1;
      pos_nxt      = (ops_left_nxt == 2'd0) ? 2'd0 : pos_r + 2'd1;
    end
    if (in_tlast) begin
      ops_left_nxt = 2'd0;
      pos_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= CMD_MOVE;
      ops_left_r <= 2'd0;
      pos_r      <= 2'd0;
    end else if (in_req) begin
      cmd_r      <= cmd_nxt;
      ops_left_r <= ops_left_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------- stage A
  logic signed [PW-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [CW-1:0] a_x_r, a_y_r;
  kind_t                a_kind_r;
  logic                 a_bad_r, a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      p_xx_r   <= coef_xx_r * in_x;
      p_xy_r   <= coef_xy_r * in_y;
      p_yx_r   <= coef_yx_r * in_x;
      p_yy_r   <= coef_yy_r * in_y;
      a_x_r    <= in_x;
      a_y_r    <= (kind_nxt == KIND_COMMAND) ? '0 : in_y;
      a_kind_r <= kind_nxt;
      a_bad_r  <= bad_nxt;
      a_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic signed [SW-1:0] sum_x, sum_y, shift_x, shift_y;
  logic signed [CW-1:0] sat_x, sat_y;
  logic                 clip_x, clip_y;

  assign sum_x   = SW'(p_xx_r) + SW'(p_xy_r) + (SW'(offset_x_r) <<< FRAC_BITS);
  assign sum_y   = SW'(p_yx_r) + SW'(p_yy_r) + (SW'(offset_y_r) <<< FRAC_BITS);
  assign shift_x = sum_x >>> FRAC_BITS;
  assign shift_y = sum_y >>> FRAC_BITS;

  // The value fits when every bit from the sign of the result up agrees.
  assign clip_x = !((&shift_x[SW-1:CW-1]) || !(|shift_x[SW-1:CW-1]));
  assign clip_y = !((&shift_y[SW-1:CW-1]) || !(|shift_y[SW-1:CW-1]));
  assign sat_x  = !clip_x ? shift_x[CW-1:0] :
                  shift_x[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign sat_y  = !clip_y ? shift_y[CW-1:0] :
                  shift_y[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};

  logic        out_valid_r;
  logic [CW-1:0] res_x_r, res_y_r;
  kind_t       res_kind_r;
  logic        res_bad_r, res_sat_r, res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      if (a_kind_r == KIND_POINT) begin
        res_x_r   <= sat_x;
        res_y_r   <= sat_y;
        res_sat_r <= clip_x || clip_y;
      end else begin
        res_x_r   <= a_x_r;
        res_y_r   <= a_y_r;
        res_sat_r <= 1'b0;
      end
      res_kind_r <= a_kind_r;
      res_bad_r  <= a_bad_r;
      res_last_r <= a_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({res_y_r, res_x_r});
  assign out_tuser  = {4'd0, res_sat_r, res_bad_r, res_kind_r};
  assign out_tlast  = res_last_r;

  // ---------------------------------------------------------------- checks
  a_bad_is_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_bad_r |-> res_kind_r == KIND_COMMAND)
    else $error("bad command flag on a non-command result");

  a_sat_is_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_sat_r |-> res_kind_r == KIND_POINT)
    else $error("saturation flag on a result that was not transformed");

  a_command_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_kind_r == KIND_COMMAND |-> res_y_r == '0)
    else $error("command result carries a nonzero y");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_req && in_tlast |=> ops_left_r == 2'd0 && pos_r == 2'd0)
    else $error("parser did not restart after the last element");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ops_left_r == 2'd0 |-> pos_r == 2'd0)
    else $error("operand position left nonzero while a command is due");

endmodule

FILE: dv/path_affine_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_affine_transform_tb: self-checking bench for the path affine transform
// Streams directed and random vector paths into the block, predicts every
// result with its own parser and fixed-point transform, and compares each
// result field by field under several matrices, idle patterns and a long
// output hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module path_affine_transform_tb;
  import pat_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] SAT_LO = -96'sh8000_0000;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    kind_t       kind;
    logic        bad;
    logic        sat;
    logic        last;
  } path_res_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [31:0] cfg_data;

  // Predictor copy of the matrix and the parser state.
  logic [31:0] m_xx = 32'h0001_0000;
  logic [31:0] m_xy = '0;
  logic [31:0] m_yx = '0;
  logic [31:0] m_yy = 32'h0001_0000;
  logic [31:0] t_x  = '0;
  logic [31:0] t_y  = '0;
  cmd_t        cur_cmd = CMD_MOVE;
  logic [1:0]  ops_left = '0;
  logic [1:0]  op_pos = '0;

  path_res_t due_results[$];
  int        n_errors = 0;
  int        items_sent = 0;
  int        n_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;

  path_affine_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("path_affine_transform_tb failed");
      $finish;
    end
  end

  // Long output hold-off, counted down here and seen by the receiver.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    out_tready = (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int operand_total(cmd_t c);
    case (c)
      CMD_MOVE, CMD_LINE:          return 1;
      CMD_CURVE, CMD_RECT, CMD_ARC: return 3;
      CMD_OVAL:                    return 2;
      default:                     return 0;
    endcase
  endfunction

  function automatic logic [31:0] cmd_word(cmd_t c);
    return {13'd0, c, 16'd0};
  endfunction

  // Returns {clipped, value}: floor of the Q16.16 sum, saturated to 32 bits.
  function automatic logic [32:0] map_coord(logic [31:0] ca, logic [31:0] cb,
                                            logic [31:0] off, logic [31:0] px,
                                            logic [31:0] py);
    logic signed [95:0] acc;
    logic signed [95:0] flo;
    acc = $signed({{64{ca[31]}}, ca}) * $signed({{64{px[31]}}, px})
        + $signed({{64{cb[31]}}, cb}) * $signed({{64{py[31]}}, py})
        + ($signed({{64{off[31]}}, off}) <<< DEF_FRAC_BITS);
    flo = acc >>> DEF_FRAC_BITS;
    if (flo > SAT_HI) return {1'b1, SAT_HI[31:0]};
    if (flo < SAT_LO) return {1'b1, SAT_LO[31:0]};
    return {1'b0, flo[31:0]};
  endfunction

  function automatic path_res_t map_element(logic [31:0] ex, logic [31:0] ey, logic el);
    path_res_t  r;
    logic       passthru;
    logic [32:0] mx;
    logic [32:0] my;
    r = '0;
    r.last = el;
    if (ops_left == 0) begin
      r.x = ex;
      r.kind = KIND_COMMAND;
      if (!ex[31] && ex[15:0] == 16'd0 && ex[30:16] <= 15'(CMD_ARC)) begin
        cur_cmd = cmd_t'(ex[18:16]);
        ops_left = 2'(operand_total(cur_cmd));
        op_pos = '0;
      end else begin
        r.bad = 1'b1;
      end
    end else begin
      passthru = (op_pos == 2'd2) && (cur_cmd == CMD_RECT || cur_cmd == CMD_ARC);
      if (passthru) begin
        r.x = ex;
        r.y = ey;
        r.kind = KIND_PASSED;
      end else begin
        mx = map_coord(m_xx, m_xy, t_x, ex, ey);
        my = map_coord(m_yx, m_yy, t_y, ex, ey);
        r.x = mx[31:0];
        r.y = my[31:0];
        r.kind = KIND_POINT;
        r.sat = mx[32] | my[32];
      end
      ops_left = ops_left - 2'd1;
      op_pos = op_pos + 2'd1;
      if (ops_left == 0) op_pos = '0;
    end
    if (el) begin
      ops_left = '0;
      op_pos = '0;
    end
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : res_check
    path_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: tdata 0x%016h tuser 0x%02h",
               out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        check_field("res_x", want.x, out_tdata[31:0]);
        check_field("res_y", want.y, out_tdata[63:32]);
        check_field("res_kind", 32'(want.kind), 32'(out_tuser[1:0]));
        check_field("res_bad_command", 32'(want.bad), 32'(out_tuser[2]));
        check_field("res_saturated", 32'(want.sat), 32'(out_tuser[3]));
        check_field("res_last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  task automatic send_elem(logic [31:0] ex, logic [31:0] ey, logic el);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {ey, ex};
    in_tlast = el;
    do @(posedge clk); while (!in_tready);
    due_results.push_back(map_element(ex, ey, el));
    items_sent++;
  endtask

  // Stop offering requests and let every expected result come out.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COEF_XX:  m_xx = val;
      REG_COEF_XY:  m_xy = val;
      REG_COEF_YX:  m_yx = val;
      REG_COEF_YY:  m_yy = val;
      REG_OFFSET_X: t_x = val;
      REG_OFFSET_Y: t_y = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                             logic [31:0] yy, logic [31:0] ox, logic [31:0] oy);
    wait_idle();
    write_reg(REG_COEF_XX, xx);
    write_reg(REG_COEF_XY, xy);
    write_reg(REG_COEF_YX, yx);
    write_reg(REG_COEF_YY, yy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 2**25)) - 2**24);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 2**19)) - 2**18);
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2**27)) - 2**26);
  endfunction

  // Command words that the parser must reject; a fully random word may by chance be valid.
  function automatic logic [31:0] bad_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {1'b1, 15'($urandom), 16'd0};
      2: return cmd_word(cmd_t'(3'($urandom_range(0, 6)))) | 32'(1 << $urandom_range(0, 15));
      default: return {1'b0, 15'($urandom_range(7, 32767)), 16'd0};
    endcase
  endfunction

  // A path of a few commands with random operands; now and then a rejected
  // command or a last mark that cuts a command short.
  task automatic send_random_path();
    int   n_cmds;
    int   n_ops;
    int   cut;
    int   roll;
    cmd_t c;
    logic fin;
    n_cmds = $urandom_range(1, 5);
    for (int i = 0; i < n_cmds; i++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_elem(bad_word(), $urandom, i == n_cmds - 1);
        continue;
      end
      c = cmd_t'(3'($urandom_range(0, 6)));
      n_ops = operand_total(c);
      cut = (roll >= 94 && n_ops > 1) ? $urandom_range(1, n_ops - 1) : n_ops;
      fin = (i == n_cmds - 1) || (cut < n_ops);
      send_elem(cmd_word(c), $urandom, fin && n_ops == 0);
      for (int j = 0; j < cut; j++)
        send_elem(rand_coord(), rand_coord(), fin && j == cut - 1);
      if (cut < n_ops) break;
    end
  endtask

  // Every command under the reset matrix, rejected codes and a cut-short curve.
  task automatic test_directed_path();
    send_elem(cmd_word(CMD_MOVE), 32'hFFFF_FFFF, 1'b0);
    send_elem(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_elem(cmd_word(CMD_LINE), '0, 1'b0);
    send_elem(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_elem(cmd_word(CMD_CURVE), '0, 1'b0);
    send_elem(32'h0001_8000, 32'hFFFE_4000, 1'b0);
    send_elem('0, '0, 1'b0);
    send_elem(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_elem(cmd_word(CMD_CLOSE), '0, 1'b0);
    send_elem(cmd_word(CMD_RECT), '0, 1'b0);
    send_elem(32'h000A_0000, 32'h0014_0000, 1'b0);
    send_elem(32'h0032_0000, 32'h0028_0000, 1'b0);
    send_elem(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_elem(cmd_word(CMD_OVAL), '0, 1'b0);
    send_elem(32'h0003_0000, 32'h0004_0000, 1'b0);
    send_elem(32'h0005_0000, 32'h0006_0000, 1'b0);
    send_elem(cmd_word(CMD_ARC), '0, 1'b0);
    send_elem(32'h0010_0000, 32'h0010_0000, 1'b0);
    send_elem(32'h0008_0000, 32'h0008_0000, 1'b0);
    send_elem(32'h7FFF_FFFF, 32'h0001_921F, 1'b1);
    // Rejected command words: fractional code, negative value, code past arc.
    send_elem(cmd_word(CMD_LINE) | 32'h0000_8000, '0, 1'b0);
    send_elem(32'hFFFF_0000, '0, 1'b0);
    send_elem(cmd_word(CMD_ARC) + 32'h0001_0000, '0, 1'b0);
    send_elem(cmd_word(CMD_CURVE), '0, 1'b0);
    send_elem(32'h0002_0000, 32'h0003_0000, 1'b1);
  endtask

  task automatic test_register_extremes();
    load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (3) send_random_path();
    load_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
    repeat (3) send_random_path();
    load_matrix('0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (3) send_random_path();
    load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    // Writes past the last register must leave the matrix alone.
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    repeat (3) send_random_path();
  endtask

  task automatic test_random_paths();
    int idle_by_phase[4]  = '{0, 65, 0, 18};
    int stall_by_phase[4] = '{0, 0, 65, 18};
    int start;
    for (int p = 0; p < 4; p++) begin
      load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_offset(), rand_offset());
      send_idle_pct = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      start = items_sent;
      while (items_sent - start < 60) begin
        if ($urandom_range(99) < 5)
          send_elem($urandom, $urandom, 1'($urandom_range(0, 1)));
        send_random_path();
      end
    end
  endtask

  // Output held off while the input keeps offering, so the block backs up.
  task automatic test_backpressure();
    int start;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    in_tvalid = 1'b0;
    hold_left = 150;
    start = items_sent;
    while (items_sent - start < 40) send_random_path();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_path();
    test_register_extremes();
    test_random_paths();
    test_backpressure();

    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("path_affine_transform_tb passed");
    end else begin
      $display("path_affine_transform_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pat_pkg.sv
src/path_affine_transform.sv
dv/path_affine_transform_tb.sv
